// File: hw/rtl/rpid_pkg.sv
`default_nettype none
package rpid_pkg;

  // Motor count and duty range
  localparam int unsigned MOTORS = 4;
  localparam int unsigned SLOTS = 4;
  localparam int unsigned PWM_LIMIT = 1000;
  localparam int unsigned DUTY_W = $clog2(PWM_LIMIT + 1);
  localparam int unsigned DUTY_OUT_W = 10;

  // Configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Lane arithmetic limits
  localparam logic signed [63:0] MEAS_HI = 64'sd1099511627776;
  localparam logic signed [63:0] MEAS_LO = -64'sd1099511627776;
  localparam logic signed [42:0] ERR_MAX = 43'sd2147483647;
  localparam logic signed [42:0] ERR_MIN = -43'sd2147483648;
  localparam logic signed [28:0] INC_MAX = 29'sd32767;
  localparam logic signed [28:0] INC_MIN = -29'sd32768;
  localparam logic signed [61:0] DIV_BIAS = 62'sd8589934591;

  localparam logic [DUTY_W-1:0] DUTY_HALF = DUTY_W'(PWM_LIMIT / 2);
  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(PWM_LIMIT);

  typedef enum logic [1:0] {
    OP_SET_SPEED = 2'd0,
    OP_TICK      = 2'd1,
    OP_RESTART   = 2'd2
  } rpid_op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_ACCEL_STEP = 3'd3,
    REG_SPEED_SCL  = 3'd4,
    REG_MOTORS_EN  = 3'd5
  } rpid_reg_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [1:0]         motor_index;
    logic signed [15:0] speed_target;
    logic signed [31:0] enc_count_0;
    logic signed [31:0] enc_count_1;
    logic signed [31:0] enc_count_2;
    logic signed [31:0] enc_count_3;
  } rpid_in_t;

  typedef struct packed {
    logic [DUTY_OUT_W-1:0] duty_0;
    logic [DUTY_OUT_W-1:0] duty_1;
    logic [DUTY_OUT_W-1:0] duty_2;
    logic [DUTY_OUT_W-1:0] duty_3;
  } rpid_out_t;

  typedef struct packed {
    logic signed [23:0] gain_p;
    logic signed [23:0] gain_i;
    logic signed [23:0] gain_d;
    logic [14:0]        accel_step;
    logic [31:0]        speed_scale;
  } rpid_cfg_t;

  typedef struct packed {
    logic               tick;
    logic               set_speed;
    logic               restart;
    logic signed [15:0] speed_target;
    logic [31:0]        enc_count;
  } rpid_lane_cmd_t;

  typedef logic [DUTY_W-1:0] rpid_duty_t;
  typedef logic [SLOTS-1:0][DUTY_W-1:0] rpid_duty_vec_t;

  typedef enum logic [3:0] {
    L_IDLE,
    L_MEAS,
    L_ERR,
    L_DIFF,
    L_MUL_P,
    L_MUL_I,
    L_MUL_D,
    L_ACC,
    L_DIV,
    L_UPD
  } rpid_lane_state_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } rpid_top_state_t;

endpackage
`default_nettype wire

// File: hw/rtl/rpid_lane.sv
`default_nettype none
module rpid_lane (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rpid_pkg::rpid_cfg_t      cfg,
  input  wire rpid_pkg::rpid_lane_cmd_t cmd,
  output logic                          busy,
  output rpid_pkg::rpid_duty_t          duty
);

  rpid_pkg::rpid_lane_state_t state_r, state_nxt;

  // Per-motor state
  logic signed [15:0]         target_r;
  logic signed [15:0]         ramped_r;
  logic [rpid_pkg::DUTY_W-1:0] duty_r;
  logic signed [31:0]         e_last_r;
  logic signed [31:0]         e_prior_r;
  logic [31:0]                last_count_r;

  // Work registers of one tick
  logic signed [31:0] delta_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] e_r;
  logic signed [35:0] dp_r;
  logic signed [35:0] di_r;
  logic signed [35:0] dd_r;
  logic signed [59:0] mul_r;
  logic signed [61:0] acc_r;
  logic signed [15:0] inc_r;

  // Ramp toward the target
  logic signed [17:0] cur_x, tgt_x, step_x, ramp_up, ramp_dn, ramp_x;
  logic signed [15:0] ramp_nxt;

  always_comb begin
    cur_x   = 18'(ramped_r);
    tgt_x   = 18'(target_r);
    step_x  = $signed({3'b000, cfg.accel_step});
    ramp_up = cur_x + step_x;
    ramp_dn = cur_x - step_x;
    if (cur_x < tgt_x) begin
      ramp_x = (ramp_up > tgt_x) ? tgt_x : ramp_up;
    end else if (cur_x > tgt_x) begin
      ramp_x = (ramp_dn < tgt_x) ? tgt_x : ramp_dn;
    end else begin
      ramp_x = tgt_x;
    end
    ramp_nxt = ramp_x[15:0];
  end

  // Measured speed: encoder delta times scale
  logic signed [32:0] scale_x;
  logic signed [64:0] meas_prod;
  assign scale_x   = $signed({1'b0, cfg.speed_scale});
  assign meas_prod = delta_r * scale_x;

  // Clamp speed, form the saturated error
  logic signed [41:0] meas_c;
  logic signed [42:0] e_full;
  logic signed [31:0] e_nxt;

  always_comb begin
    if (prod_r > rpid_pkg::MEAS_HI) begin
      meas_c = 42'(rpid_pkg::MEAS_HI);
    end else if (prod_r < rpid_pkg::MEAS_LO) begin
      meas_c = 42'(rpid_pkg::MEAS_LO);
    end else begin
      meas_c = prod_r[41:0];
    end
    e_full = 43'($signed({ramped_r, 16'h0000})) - 43'(meas_c);
    if (e_full > rpid_pkg::ERR_MAX) begin
      e_nxt = 32'(rpid_pkg::ERR_MAX);
    end else if (e_full < rpid_pkg::ERR_MIN) begin
      e_nxt = 32'(rpid_pkg::ERR_MIN);
    end else begin
      e_nxt = e_full[31:0];
    end
  end

  // Error differences, P and D terms doubled
  logic signed [35:0] dp_x, di_x, dd_x;

  always_comb begin
    dp_x = 36'(e_r) - 36'(e_last_r);
    di_x = 36'(e_r) + 36'(e_last_r);
    dd_x = 36'(e_r) - (36'(e_last_r) <<< 1) + 36'(e_prior_r);
  end

  // Shared gain multiplier
  logic signed [23:0] gain_sel;
  logic signed [35:0] diff_sel;
  logic signed [59:0] mul_nxt;

  always_comb begin
    unique case (state_r)
      rpid_pkg::L_MUL_I: begin
        gain_sel = cfg.gain_i;
        diff_sel = di_r;
      end
      rpid_pkg::L_MUL_D: begin
        gain_sel = cfg.gain_d;
        diff_sel = dd_r;
      end
      default: begin
        gain_sel = cfg.gain_p;
        diff_sel = dp_r;
      end
    endcase
    mul_nxt = gain_sel * diff_sel;
  end

  // Divide by 2^33 toward zero, saturate to int16
  logic signed [61:0] acc_adj;
  logic signed [28:0] quot;
  logic signed [15:0] inc_nxt;

  always_comb begin
    acc_adj = acc_r + (acc_r[61] ? rpid_pkg::DIV_BIAS : 62'sd0);
    quot    = acc_adj[61:33];
    if (quot > rpid_pkg::INC_MAX) begin
      inc_nxt = 16'(rpid_pkg::INC_MAX);
    end else if (quot < rpid_pkg::INC_MIN) begin
      inc_nxt = 16'(rpid_pkg::INC_MIN);
    end else begin
      inc_nxt = quot[15:0];
    end
  end

  // New duty, clamped to the PWM range
  logic signed [17:0] duty_sum;
  logic [rpid_pkg::DUTY_W-1:0] duty_nxt;

  always_comb begin
    duty_sum = $signed(18'(duty_r)) + 18'(inc_r);
    if (duty_sum < 18'sd0) begin
      duty_nxt = '0;
    end else if (duty_sum > $signed(18'(rpid_pkg::PWM_LIMIT))) begin
      duty_nxt = rpid_pkg::DUTY_MAX;
    end else begin
      duty_nxt = duty_sum[rpid_pkg::DUTY_W-1:0];
    end
  end

  // Step sequencer
  always_comb begin
    unique case (state_r)
      rpid_pkg::L_IDLE:  state_nxt = cmd.tick ? rpid_pkg::L_MEAS : rpid_pkg::L_IDLE;
      rpid_pkg::L_MEAS:  state_nxt = rpid_pkg::L_ERR;
      rpid_pkg::L_ERR:   state_nxt = rpid_pkg::L_DIFF;
      rpid_pkg::L_DIFF:  state_nxt = rpid_pkg::L_MUL_P;
      rpid_pkg::L_MUL_P: state_nxt = rpid_pkg::L_MUL_I;
      rpid_pkg::L_MUL_I: state_nxt = rpid_pkg::L_MUL_D;
      rpid_pkg::L_MUL_D: state_nxt = rpid_pkg::L_ACC;
      rpid_pkg::L_ACC:   state_nxt = rpid_pkg::L_DIV;
      rpid_pkg::L_DIV:   state_nxt = rpid_pkg::L_UPD;
      rpid_pkg::L_UPD:   state_nxt = rpid_pkg::L_IDLE;
      default:           state_nxt = rpid_pkg::L_IDLE;
    endcase
    busy = (state_r != rpid_pkg::L_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpid_pkg::L_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Motor state: reset and restart, target write, tick start and write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r     <= '0;
      ramped_r     <= '0;
      duty_r       <= rpid_pkg::DUTY_HALF;
      e_last_r     <= '0;
      e_prior_r    <= '0;
      last_count_r <= '0;
    end else if (cmd.restart) begin
      target_r     <= '0;
      ramped_r     <= '0;
      duty_r       <= rpid_pkg::DUTY_HALF;
      e_last_r     <= '0;
      e_prior_r    <= '0;
      last_count_r <= cmd.enc_count;
    end else begin
      if (cmd.set_speed) begin
        target_r <= cmd.speed_target;
      end
      if (state_r == rpid_pkg::L_IDLE && cmd.tick) begin
        ramped_r     <= ramp_nxt;
        last_count_r <= cmd.enc_count;
      end
      if (state_r == rpid_pkg::L_UPD) begin
        duty_r    <= duty_nxt;
        e_prior_r <= e_last_r;
        e_last_r  <= e_r;
      end
    end
  end

  // Datapath work registers
  always_ff @(posedge clk) begin
    if (state_r == rpid_pkg::L_IDLE && cmd.tick) begin
      delta_r <= $signed(cmd.enc_count - last_count_r);
    end
    if (state_r == rpid_pkg::L_MEAS) begin
      prod_r <= meas_prod[63:0];
    end
    if (state_r == rpid_pkg::L_ERR) begin
      e_r <= e_nxt;
    end
    if (state_r == rpid_pkg::L_DIFF) begin
      dp_r <= dp_x <<< 1;
      di_r <= di_x;
      dd_r <= dd_x <<< 1;
    end
    mul_r <= mul_nxt;
    if (state_r == rpid_pkg::L_MUL_I) begin
      acc_r <= 62'(mul_r);
    end else if (state_r == rpid_pkg::L_MUL_D || state_r == rpid_pkg::L_ACC) begin
      acc_r <= acc_r + 62'(mul_r);
    end
    if (state_r == rpid_pkg::L_DIV) begin
      inc_r <= inc_nxt;
    end
  end

  assign duty = duty_r;

endmodule
`default_nettype wire

// File: hw/rtl/rpid_merge.sv
`default_nettype none
module rpid_merge (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     load,
  input  wire rpid_pkg::rpid_duty_vec_t duty_vec,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output rpid_pkg::rpid_out_t           out_data,
  output logic                          free
);

  logic                out_valid_r;
  rpid_pkg::rpid_out_t out_data_r, out_data_nxt;

  // Gather lane duties into one word
  always_comb begin
    out_data_nxt.duty_0 = rpid_pkg::DUTY_OUT_W'(duty_vec[0]);
    out_data_nxt.duty_1 = rpid_pkg::DUTY_OUT_W'(duty_vec[1]);
    out_data_nxt.duty_2 = rpid_pkg::DUTY_OUT_W'(duty_vec[2]);
    out_data_nxt.duty_3 = rpid_pkg::DUTY_OUT_W'(duty_vec[3]);
  end

  assign free = !out_valid_r || !out_stall;

  // Hold the word until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: hw/rtl/ramped_incremental_pid_speed_loop_top.sv
`default_nettype none
// Channel   Direction  Handshake            Word
// in_*      input      in_valid/in_stall    rpid_in_t: operation, target, encoder counts
// out_*     output     out_valid/out_stall  rpid_out_t: duty of each motor
// cfg_*     input      cfg_wr_en            cfg_index selects, cfg_wdata carries the value
//
// Set speed and restart words leave the sequencer idle; the next word is taken the cycle after.
// A tick walks each enabled lane through measure, error, differences, P, I and D products,
// accumulate, divide, update on its own shared gain multiplier; then merge loads the duty word.
// A finished tick waits in RUN only while the output register still holds an untaken word.
// Synchronous reset gives each lane duty at half the PWM limit, the rest zero; restart loads the encoder count.
module ramped_incremental_pid_speed_loop_top (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire rpid_pkg::rpid_in_t               in_data,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output rpid_pkg::rpid_out_t                   out_data,
  input  wire logic                             cfg_wr_en,
  input  wire logic [rpid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rpid_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // Configuration registers
  logic signed [23:0] gain_p_r, gain_i_r, gain_d_r;
  logic [14:0]        accel_step_r;
  logic [31:0]        speed_scale_r;
  logic [2:0]         motors_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r      <= '0;
      gain_i_r      <= '0;
      gain_d_r      <= '0;
      accel_step_r  <= 15'd1;
      speed_scale_r <= 32'd65536;
      motors_en_r   <= 3'd4;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        rpid_pkg::REG_GAIN_P:     gain_p_r      <= cfg_wdata[23:0];
        rpid_pkg::REG_GAIN_I:     gain_i_r      <= cfg_wdata[23:0];
        rpid_pkg::REG_GAIN_D:     gain_d_r      <= cfg_wdata[23:0];
        rpid_pkg::REG_ACCEL_STEP: accel_step_r  <= cfg_wdata[14:0];
        rpid_pkg::REG_SPEED_SCL:  speed_scale_r <= cfg_wdata[31:0];
        rpid_pkg::REG_MOTORS_EN:  motors_en_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  rpid_pkg::rpid_cfg_t lane_cfg;
  always_comb begin
    lane_cfg.gain_p      = gain_p_r;
    lane_cfg.gain_i      = gain_i_r;
    lane_cfg.gain_d      = gain_d_r;
    lane_cfg.accel_step  = accel_step_r;
    lane_cfg.speed_scale = speed_scale_r;
  end

  // Enabled motor count, limited to the lanes present
  logic [2:0] motors_n;
  assign motors_n = (motors_en_r > 3'(rpid_pkg::MOTORS)) ? 3'(rpid_pkg::MOTORS) : motors_en_r;

  rpid_pkg::rpid_top_state_t state_r, state_nxt;
  logic in_acc;
  logic load;
  logic out_free;
  logic any_busy;

  assign in_acc = in_valid && !in_stall;

  logic [rpid_pkg::SLOTS-1:0][31:0] enc_vec;
  assign enc_vec = {in_data.enc_count_3, in_data.enc_count_2,
                    in_data.enc_count_1, in_data.enc_count_0};

  logic [rpid_pkg::SLOTS-1:0] lane_busy;
  rpid_pkg::rpid_duty_vec_t   lane_duty;

  // One lane per motor; absent slots read zero
  for (genvar k = 0; k < rpid_pkg::SLOTS; k++) begin : g_lane
    if (k < rpid_pkg::MOTORS) begin : g_on
      rpid_pkg::rpid_lane_cmd_t cmd;
      always_comb begin
        cmd.tick         = in_acc && (in_data.operation == rpid_pkg::OP_TICK)
                           && (3'(k) < motors_n);
        cmd.set_speed    = in_acc && (in_data.operation == rpid_pkg::OP_SET_SPEED)
                           && (in_data.motor_index == 2'(k));
        cmd.restart      = in_acc && (in_data.operation == rpid_pkg::OP_RESTART);
        cmd.speed_target = in_data.speed_target;
        cmd.enc_count    = enc_vec[k];
      end
      rpid_lane u_lane (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (lane_cfg),
        .cmd  (cmd),
        .busy (lane_busy[k]),
        .duty (lane_duty[k])
      );
    end else begin : g_off
      assign lane_busy[k] = 1'b0;
      assign lane_duty[k] = '0;
    end
  end

  assign any_busy = |lane_busy;

  // Sequence: idle takes words, run waits for lanes and a free output register
  always_comb begin
    state_nxt = state_r;
    load      = 1'b0;
    unique case (state_r)
      rpid_pkg::S_IDLE: begin
        if (in_acc && in_data.operation == rpid_pkg::OP_TICK) begin
          state_nxt = rpid_pkg::S_RUN;
        end
      end
      rpid_pkg::S_RUN: begin
        if (!any_busy && out_free) begin
          load      = 1'b1;
          state_nxt = rpid_pkg::S_IDLE;
        end
      end
      default: state_nxt = rpid_pkg::S_IDLE;
    endcase
    in_stall = (state_r != rpid_pkg::S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpid_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  rpid_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load),
    .duty_vec (lane_duty),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .out_data (out_data),
    .free     (out_free)
  );

  // A tick word always starts a run
  a_tick_runs: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.operation == rpid_pkg::OP_TICK |=> state_r == rpid_pkg::S_RUN)
    else $error("tick accepted without entering run");

  // Lanes work only while the sequencer is in run
  a_idle_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rpid_pkg::S_IDLE |-> !any_busy)
    else $error("lane busy while sequencer idle");

  // Duties stay inside the PWM range
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    lane_duty[0] <= rpid_pkg::DUTY_MAX && lane_duty[1] <= rpid_pkg::DUTY_MAX &&
    lane_duty[2] <= rpid_pkg::DUTY_MAX && lane_duty[3] <= rpid_pkg::DUTY_MAX)
    else $error("duty above PWM limit");

  // A finished run shows its word next cycle
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid)
    else $error("result word lost at load");

endmodule
`default_nettype wire
